### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWAS_ASSERT_IMPLY(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("swas assertion failed");

// next-cycle implication
`define SWAS_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("swas assertion failed");

`endif

### hdl/swas_pkg.sv
// ----------------------------------------------------------------------------
// swas_pkg
// Types and constants of the scan window average segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package swas_pkg;

  localparam int RANGE_W     = 16;
  localparam int BEAM_IDX_W  = 10;
  localparam int CFG_W       = 32;
  localparam int COS_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int Q15_SHIFT   = 15;
  localparam int QUEUE_DEPTH = 2;
  localparam int MOD_W       = 3;

  localparam logic [MOD_W-1:0] SLOT_STRIDE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_BREAK_DIST_SQ = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_STEP      = 1'd1;

  localparam logic [CFG_W-1:0] BREAK_DIST_RESET = 32'd10000;
  localparam logic [COS_W-1:0] COS_STEP_RESET   = 16'd32767;

  typedef struct packed {
    logic last;
    logic first;
    logic emit;
  } swas_flags_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MEAN,
    ST_SQUARE,
    ST_SCALE,
    ST_DECIDE
  } swas_state_t;

endpackage

`default_nettype wire

### hdl/swas_if.sv
// ----------------------------------------------------------------------------
// swas stream interfaces
// Valid/ready channels for range samples and segment results.
// ----------------------------------------------------------------------------
`default_nettype none

interface swas_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        scan_end;

  modport source (output valid, output range_mm, output scan_end, input ready);
  modport sink   (input valid, input range_mm, input scan_end, output ready);
endinterface

interface swas_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  beam_index;
  logic [15:0] mean_range_mm;
  logic        segment_break;
  logic        last_beam;

  modport source (output valid, output beam_index, output mean_range_mm,
                  output segment_break, output last_beam, input ready);
  modport sink   (input valid, input beam_index, input mean_range_mm,
                  input segment_break, input last_beam, output ready);
endinterface

`default_nettype wire

### hdl/swas_ram.sv
// ----------------------------------------------------------------------------
// swas_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### hdl/swas_queue.sv
// ----------------------------------------------------------------------------
// swas_queue
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module swas_queue #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic      [WIDTH-1:0] pop_data
);
  import swas_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hdl/swas_front.sv
// ----------------------------------------------------------------------------
// swas_front
// Accepts samples, counts arrivals, tracks scan slot and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module swas_front #(
  parameter int BEAMS  = 1024,
  parameter int WINDOW = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  swas_in_if.sink                                in_strm,
  input  wire logic                              clearing,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output logic [$clog2(WINDOW*BEAMS)-1:0]        cmd_addr,
  output logic [$clog2(BEAMS)-1:0]               cmd_beam,
  output logic [swas_pkg::RANGE_W-1:0]           cmd_range,
  output swas_pkg::swas_flags_t                  cmd_flags
);
  import swas_pkg::*;

  localparam int BW  = $clog2(BEAMS);
  localparam int AW  = $clog2(WINDOW * BEAMS);
  localparam int ARW = $clog2(BEAMS + 1);
  localparam int SLW = $clog2(WINDOW);

  logic [ARW-1:0]   arrival_r, arrival_nxt;
  logic [SLW-1:0]   slot_r, slot_nxt;
  logic [MOD_W-1:0] mod_r, mod_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic             accept, live, slot_wrap;

  assign in_strm.ready = !clearing && !q_full;
  assign accept        = in_strm.valid && in_strm.ready;
  assign live          = (arrival_r < ARW'(BEAMS));
  assign q_push        = accept && live;
  assign slot_wrap     = (slot_r == SLW'(WINDOW - 1));

  assign cmd_beam        = BW'(BEAMS - 1) - arrival_r[BW-1:0];
  assign cmd_addr        = base_r + AW'(cmd_beam);
  assign cmd_range       = in_strm.range_mm;
  assign cmd_flags.last  = in_strm.scan_end;
  assign cmd_flags.first = (arrival_r == '0);
  assign cmd_flags.emit  = (mod_r == '0);

  always_comb begin
    arrival_nxt = arrival_r;
    slot_nxt    = slot_r;
    mod_nxt     = mod_r;
    base_nxt    = base_r;
    if (q_push) begin
      arrival_nxt = arrival_r + 1'b1;
    end
    if (accept && in_strm.scan_end) begin
      arrival_nxt = '0;
      if (slot_wrap) begin
        slot_nxt = '0;
        mod_nxt  = '0;
        base_nxt = '0;
      end else begin
        slot_nxt = slot_r + 1'b1;
        mod_nxt  = (mod_r == SLOT_STRIDE - 1'b1) ? '0 : mod_r + 1'b1;
        base_nxt = base_r + AW'(BEAMS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r <= '0;
      slot_r    <= SLW'(1);
      mod_r     <= MOD_W'(1);
      base_r    <= AW'(BEAMS);
    end else begin
      arrival_r <= arrival_nxt;
      slot_r    <= slot_nxt;
      mod_r     <= mod_nxt;
      base_r    <= base_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/swas_back.sv
// ----------------------------------------------------------------------------
// swas_back
// Window and sum update, window mean and break test, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swas_back #(
  parameter int BEAMS  = 1024,
  parameter int WINDOW = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [swas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [swas_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic                               q_valid,
  output logic                                    q_pop,
  input  wire logic [$clog2(WINDOW*BEAMS)-1:0]    cmd_addr,
  input  wire logic [$clog2(BEAMS)-1:0]           cmd_beam,
  input  wire logic [swas_pkg::RANGE_W-1:0]       cmd_range,
  input  wire swas_pkg::swas_flags_t              cmd_flags,
  output logic                                    clearing,
  swas_out_if.source                              out_strm
);
  import swas_pkg::*;

  localparam int BW   = $clog2(BEAMS);
  localparam int AW   = $clog2(WINDOW * BEAMS);
  localparam int LW   = $clog2(WINDOW);
  localparam int SW   = RANGE_W + LW;
  localparam int RSH  = SW + LW;
  localparam int MW   = SW + 1;
  localparam int PRW  = SW + MW;
  localparam int CMPW = 2 * RANGE_W + Q15_SHIFT + 3;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << RSH) + WINDOW - 1) / WINDOW);

  swas_state_t state_r, state_nxt;

  logic [AW-1:0]          clr_r, clr_nxt;
  logic [AW-1:0]          addr_r;
  logic [BW-1:0]          beam_r;
  logic [RANGE_W-1:0]     range_r;
  swas_flags_t            flags_r;
  logic [SW-1:0]          sum_r;
  logic [PRW-1:0]         prod_r;
  logic [RANGE_W-1:0]     mean_r;
  logic [2*RANGE_W:0]     sumsq_r;
  logic [2*RANGE_W-1:0]   ab_r;
  logic [2*RANGE_W+COS_W-1:0] abc_r;
  logic [RANGE_W-1:0]     prev_r, prev_nxt;
  logic [CFG_W-1:0]       brk_dist_r, brk_dist_nxt;
  logic [COS_W-1:0]       cos_r, cos_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [BEAM_IDX_W-1:0]  out_beam_r;
  logic [RANGE_W-1:0]     out_mean_r;
  logic                   out_brk_r, out_last_r;
  logic                   out_load;

  logic                   win_we, sum_we;
  logic [AW-1:0]          win_waddr;
  logic [RANGE_W-1:0]     win_wdata, win_rdata;
  logic [BW-1:0]          sum_waddr;
  logic [SW-1:0]          sum_wdata, sum_rdata, sum_upd;

  logic [RANGE_W-1:0]     mean_w;
  logic [2*RANGE_W-1:0]   sq_a, sq_b;
  logic [CMPW-1:0]        lhs, rhs;
  logic                   over, brk;
  logic [BW+BEAM_IDX_W-1:0] beam_ext;

  swas_ram #(.WIDTH(RANGE_W), .DEPTH(WINDOW * BEAMS)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .raddr (cmd_addr),
    .rdata (win_rdata)
  );

  swas_ram #(.WIDTH(SW), .DEPTH(BEAMS)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (cmd_beam),
    .rdata (sum_rdata)
  );

  assign sum_upd  = sum_rdata - SW'(win_rdata) + SW'(range_r);
  assign mean_w   = prod_r[RSH +: RANGE_W];
  assign sq_a     = mean_w * mean_w;
  assign sq_b     = prev_r * prev_r;
  assign lhs      = CMPW'({sumsq_r, {Q15_SHIFT{1'b0}}});
  assign rhs      = CMPW'({brk_dist_r, {Q15_SHIFT{1'b0}}}) + CMPW'({abc_r, 1'b0});
  assign over     = (lhs > rhs);
  assign brk      = !flags_r.first && over;
  assign beam_ext = {{BEAM_IDX_W{1'b0}}, beam_r};
  assign clearing = (state_r == ST_CLEAR);

  assign out_strm.valid         = out_valid_r;
  assign out_strm.beam_index    = out_beam_r;
  assign out_strm.mean_range_mm = out_mean_r;
  assign out_strm.segment_break = out_brk_r;
  assign out_strm.last_beam     = out_last_r;

  // configuration decode
  always_comb begin
    brk_dist_nxt = brk_dist_r;
    cos_nxt      = cos_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_BREAK_DIST_SQ: brk_dist_nxt = cfg_wdata;
        REG_COS_STEP:      cos_nxt      = cfg_wdata[COS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    prev_nxt  = prev_r;
    q_pop     = 1'b0;
    win_we    = 1'b0;
    win_waddr = addr_r;
    win_wdata = range_r;
    sum_we    = 1'b0;
    sum_waddr = beam_r;
    sum_wdata = sum_upd;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        win_we    = 1'b1;
        win_waddr = clr_r;
        win_wdata = '0;
        sum_we    = (clr_r < AW'(BEAMS));
        sum_waddr = clr_r[BW-1:0];
        sum_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(WINDOW * BEAMS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        win_we    = 1'b1;
        sum_we    = 1'b1;
        state_nxt = ST_MEAN;
      end
      ST_MEAN:   state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        // hold while an emitting sample finds the result register occupied and not taken
        if (!(flags_r.emit && out_valid_r && !out_strm.ready)) begin
          out_load  = flags_r.emit;
          prev_nxt  = mean_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_strm.ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      prev_r      <= '0;
      brk_dist_r  <= BREAK_DIST_RESET;
      cos_r       <= COS_STEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      prev_r      <= prev_nxt;
      brk_dist_r  <= brk_dist_nxt;
      cos_r       <= cos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      addr_r  <= cmd_addr;
      beam_r  <= cmd_beam;
      range_r <= cmd_range;
      flags_r <= cmd_flags;
    end
    if (state_r == ST_READ) begin
      sum_r <= sum_upd;
    end
    if (state_r == ST_MEAN) begin
      prod_r <= PRW'(sum_r) * PRW'(RECIP);
    end
    if (state_r == ST_SQUARE) begin
      mean_r  <= mean_w;
      sumsq_r <= {1'b0, sq_a} + {1'b0, sq_b};
      ab_r    <= mean_w * prev_r;
    end
    if (state_r == ST_SCALE) begin
      abc_r <= ab_r * cos_r;
    end
    if (out_load) begin
      out_beam_r <= beam_ext[BEAM_IDX_W-1:0];
      out_mean_r <= mean_r;
      out_brk_r  <= brk;
      out_last_r <= flags_r.last;
    end
  end

endmodule

`default_nettype wire

### hdl/scan_window_average_segmenter_unit.sv
// ----------------------------------------------------------------------------
// scan_window_average_segmenter_unit
// Per-beam moving window mean of laser ranges with breakpoint flags.
// ----------------------------------------------------------------------------
//  port group | direction | payload
//  in_strm    | sink      | range_mm[15:0], scan_end
//  out_strm   | source    | beam_index[9:0], mean_range_mm[15:0], segment_break,
//             |           | last_beam
//  cfg_*      | write     | cfg_index[0], cfg_wdata[31:0]
//
//  Each stored sample passes the back-end sequencer steps in order (queue pop
//  with window and sum read, write-back, reciprocal multiply, squares, cosine
//  product, compare); samples past BEAMS in a scan are accepted and dropped.
//  After reset a clearing pass zeroing both RAMs holds in_strm.ready low.
//  A two-entry queue lets the front take samples while the back works; a full
//  result register stalls an emitting sample in the back end's final step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module scan_window_average_segmenter_unit #(
  parameter int BEAMS  = 1024,
  parameter int WINDOW = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  swas_in_if.sink                             in_strm,
  swas_out_if.source                          out_strm,
  input  wire logic                           cfg_we,
  input  wire logic [swas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [swas_pkg::CFG_W-1:0]     cfg_wdata
);
  import swas_pkg::*;

  localparam int BW = $clog2(BEAMS);
  localparam int AW = $clog2(WINDOW * BEAMS);
  localparam int QW = AW + BW + RANGE_W + $bits(swas_flags_t);

  logic              clearing, q_full, q_push, q_pop, q_valid;
  logic [AW-1:0]     f_addr, b_addr;
  logic [BW-1:0]     f_beam, b_beam;
  logic [RANGE_W-1:0] f_range, b_range;
  swas_flags_t       f_flags, b_flags;
  logic [QW-1:0]     q_wdata, q_rdata;

  swas_front #(.BEAMS(BEAMS), .WINDOW(WINDOW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_strm   (in_strm),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .cmd_addr  (f_addr),
    .cmd_beam  (f_beam),
    .cmd_range (f_range),
    .cmd_flags (f_flags)
  );

  assign q_wdata = {f_addr, f_beam, f_range, f_flags};

  swas_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  assign {b_addr, b_beam, b_range, b_flags} = q_rdata;

  swas_back #(.BEAMS(BEAMS), .WINDOW(WINDOW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .cmd_addr  (b_addr),
    .cmd_beam  (b_beam),
    .cmd_range (b_range),
    .cmd_flags (b_flags),
    .clearing  (clearing),
    .out_strm  (out_strm)
  );

  `SWAS_ASSERT_IMPLY(a_clear_blocks_input, clearing, !in_strm.ready)
  `SWAS_ASSERT_IMPLY(a_no_push_when_full, q_full, !q_push)
  `SWAS_ASSERT_IMPLY(a_no_pop_while_clearing, clearing, !q_pop)
  `SWAS_ASSERT_NEXT(a_push_lands, q_push, q_valid)

endmodule

`default_nettype wire
